/* rtl/core/bpct_pkg.sv */
// Shared types and constants for the battery ADC to percent block.
// Holds the discharge curve table, field widths and the controller/datapath
// command and status structs. No dependencies.
package bpct_pkg;

    // Field widths
    localparam int MV_W         = 13;
    localparam int PCT_W        = 7;
    localparam int ADC_BITS_DEF = 12;

    // Scaling: mv = 2 * (raw * 600 * 6 / full_scale)
    localparam int SCALE_W = 12;
    localparam logic [SCALE_W-1:0] SCALE_MUL = SCALE_W'(600 * 6);

    // Quotient bits of the scaled reading and of the divider; both stay below 4096
    localparam int QUOT_W = 12;

    // Discharge curve, high voltage first
    localparam int CURVE_POINTS = 21;
    localparam int SEG_W        = $clog2(CURVE_POINTS);

    localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);
    localparam logic [PCT_W-1:0] PCT_ZERO = '0;

    localparam logic [MV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
        13'd4200, 13'd4150, 13'd4110, 13'd4080, 13'd4020, 13'd3980, 13'd3920,
        13'd3870, 13'd3820, 13'd3790, 13'd3770, 13'd3750, 13'd3730, 13'd3710,
        13'd3690, 13'd3610, 13'd3530, 13'd3450, 13'd3370, 13'd3280, 13'd3000
    };

    localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
        7'd100, 7'd95, 7'd90, 7'd85, 7'd80, 7'd75, 7'd70,
        7'd65,  7'd60, 7'd55, 7'd50, 7'd45, 7'd40, 7'd35,
        7'd30,  7'd25, 7'd20, 7'd15, 7'd10, 7'd5,  7'd0
    };

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_RANGE,
        ST_SEARCH,
        ST_INTERP,
        ST_DONE
    } bpct_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_zero;
        logic start_scale;
        logic cap_mv;
        logic pct_full;
        logic pct_zero;
        logic seg_init;
        logic seg_step;
        logic pct_upper;
        logic start_interp;
        logic cap_pct;
        logic out_load;
    } bpct_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic skip;
        logic scale_done;
        logic div_done;
        logic mv_ge_top;
        logic mv_le_bot;
        logic seg_hit;
        logic seg_flat;
        logic seg_last;
        logic out_free;
    } bpct_sts_t;

endpackage

/* rtl/core/battery_adc_to_percent.sv */
// Top level of the battery ADC to percent block: controller plus datapath.
// Depends on bpct_pkg, bpct_ctrl, bpct_dp (and bpct_div through bpct_dp).
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid / in_ready   adc_raw, read_failed
//   out      output     out_valid / out_ready supply_mv, battery_pct
//   cfg      input      cfg_we (no wait)      cfg_wdata -> block_enabled
//
// One item at a time. A disabled block or failed read skips from the accepting
// state to the output load. Otherwise: scaling (multiply, shift-add estimate,
// remainder check) and a range check, then the output load at or beyond the
// curve ends; inside the curve a segment walk, a one-bit-a-cycle interpolation
// divide and the output load. A new item is taken once the previous result
// sits in the output register; the load stalls while that register is still
// waiting for out_ready. Reset clears the enable bit.
module battery_adc_to_percent #(
    parameter int ADC_BITS = bpct_pkg::ADC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ADC_BITS-1:0]        adc_raw,
    input  logic                       read_failed,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [bpct_pkg::MV_W-1:0]  supply_mv,
    output logic [bpct_pkg::PCT_W-1:0] battery_pct
);

    import bpct_pkg::*;

    bpct_cmd_t cmd;
    bpct_sts_t sts;

    // Sequencer
    bpct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Arithmetic and result registers
    bpct_dp #(
        .ADC_BITS (ADC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .adc_raw     (adc_raw),
        .read_failed (read_failed),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .supply_mv   (supply_mv),
        .battery_pct (battery_pct)
    );

endmodule

/* rtl/core/bpct_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Used for the curve interpolation. No dependencies.
module bpct_div #(
    parameter int DW = 24,
    parameter int VW = 13,
    parameter int QW = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [QW-1:0] quotient
);

    localparam int CW = (QW > 1) ? $clog2(QW) : 1;

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dvs_reg;
    logic [QW-1:0] low_reg;

    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          fits;
    logic [VW-1:0] rem_next;

    // Trial subtract of the divisor from the shifted remainder
    always_comb
    begin
        trial    = {rem_reg, low_reg[QW-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = (trial >= {1'b0, dvs_reg});
        rem_next = fits ? diff[VW-1:0] : trial[VW-1:0];
    end

    // Control: count the steps and flag the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(QW - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                    busy_reg <= 1'b0;
                else
                    cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Datapath: remainder and dividend/quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= VW'(dividend >> QW);
            low_reg <= dividend[QW-1:0];
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[QW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = low_reg;

endmodule

/* rtl/core/bpct_dp.sv */
// Datapath: enable register, ADC scaling, curve segment walk, interpolation
// and output register. Depends on bpct_pkg and bpct_div.
module bpct_dp #(
    parameter int ADC_BITS = bpct_pkg::ADC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bpct_pkg::bpct_cmd_t        cmd,
    output bpct_pkg::bpct_sts_t        sts,
    input  logic                       cfg_we,
    input  logic                       cfg_wdata,
    input  logic [ADC_BITS-1:0]        adc_raw,
    input  logic                       read_failed,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic [bpct_pkg::MV_W-1:0]  supply_mv,
    output logic [bpct_pkg::PCT_W-1:0] battery_pct
);

    import bpct_pkg::*;

    localparam int PW = ADC_BITS + SCALE_W;
    localparam int DW = MV_W + PCT_W;
    localparam logic [ADC_BITS:0] FULL_SCALE = {1'b0, {ADC_BITS{1'b1}}};

    logic                    enabled_reg;
    logic [MV_W-1:0]         mv_reg;
    logic [PCT_W-1:0]        pct_reg;
    logic [SEG_W-1:0]        k_reg;
    logic                    out_valid_reg;
    logic [MV_W-1:0]         out_mv_reg;
    logic [PCT_W-1:0]        out_pct_reg;

    logic [PW-1:0]           sc_prod_reg;
    logic [QUOT_W-1:0]       sc_est_reg;
    logic [ADC_BITS:0]       sc_rem_reg;
    logic [2:0]              sc_stage_reg;

    logic [PW-1:0]           scale_prod;
    logic [PW:0]             sc_sum;
    logic [QUOT_W-1:0]       sc_est;
    logic [PW-1:0]           sc_rem;
    logic [QUOT_W-1:0]       sc_quot;
    logic [SEG_W-1:0]        k_low;
    logic [MV_W-1:0]         vh;
    logic [MV_W-1:0]         vl;
    logic [PCT_W-1:0]        ph;
    logic [PCT_W-1:0]        pl;
    logic [MV_W-1:0]         dv;
    logic [PCT_W-1:0]        dp;
    logic [MV_W-1:0]         mv_off;
    logic [MV_W+PCT_W-1:0]   seg_prod;

    logic                    div_start;
    logic                    div_done;
    logic [QUOT_W-1:0]       div_quot;

    // Enable register; the user must write it only while the block is idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            enabled_reg <= 1'b0;
        else if (cfg_we)
            enabled_reg <= cfg_wdata;
    end

    // Scale the raw reading by 600 * 6 ahead of the divide
    assign scale_prod = {{SCALE_W{1'b0}}, adc_raw} * {{ADC_BITS{1'b0}}, SCALE_MUL};

    // Divide by 2^ADC_BITS - 1: shift-add estimate, low by at most one,
    // then a remainder check to fix it up
    always_comb
    begin
        sc_sum  = {1'b0, sc_prod_reg} + {1'b0, (sc_prod_reg >> ADC_BITS)};
        sc_est  = QUOT_W'(sc_sum >> ADC_BITS);
        sc_rem  = sc_prod_reg - PW'({sc_est_reg, {ADC_BITS{1'b0}}}) + PW'(sc_est_reg);
        sc_quot = sc_est_reg + QUOT_W'(sc_rem_reg >= FULL_SCALE);
    end

    // Advance the scaling stages: product, estimate, remainder
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sc_stage_reg <= '0;
        else
            sc_stage_reg <= {sc_stage_reg[1:0], cmd.start_scale};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_scale)
            sc_prod_reg <= scale_prod;
        if (sc_stage_reg[0])
            sc_est_reg <= sc_est;
        if (sc_stage_reg[1])
            sc_rem_reg <= sc_rem[ADC_BITS:0];
    end

    // Current segment: upper point k, lower point k + 1
    always_comb
    begin
        k_low    = k_reg + 1'b1;
        vh       = CURVE_MV[k_reg];
        vl       = CURVE_MV[k_low];
        ph       = CURVE_PCT[k_reg];
        pl       = CURVE_PCT[k_low];
        dv       = vh - vl;
        dp       = (ph < pl) ? PCT_ZERO : (ph - pl);
        mv_off   = mv_reg - vl;
        seg_prod = {{PCT_W{1'b0}}, mv_off} * {{MV_W{1'b0}}, dp};
    end

    // Interpolation divide
    assign div_start = cmd.start_interp;

    bpct_div #(
        .DW (DW),
        .VW (MV_W),
        .QW (QUOT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (seg_prod),
        .divisor  (dv),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Working result registers and segment index
    always_ff @(posedge clk)
    begin
        if (cmd.load_zero)
        begin
            mv_reg  <= '0;
            pct_reg <= PCT_ZERO;
        end
        if (cmd.cap_mv)
            mv_reg <= MV_W'({sc_quot, 1'b0});
        if (cmd.pct_full)
            pct_reg <= PCT_FULL;
        if (cmd.pct_zero)
            pct_reg <= PCT_ZERO;
        if (cmd.pct_upper)
            pct_reg <= ph;
        if (cmd.cap_pct)
            pct_reg <= pl + div_quot[PCT_W-1:0];
        if (cmd.seg_init)
            k_reg <= '0;
        else if (cmd.seg_step)
            k_reg <= k_low;
    end

    // Output register: hold the result until the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_mv_reg  <= mv_reg;
            out_pct_reg <= pct_reg;
        end
    end

    // Status towards the controller
    always_comb
    begin
        sts.skip       = !enabled_reg || read_failed;
        sts.scale_done = sc_stage_reg[2];
        sts.div_done   = div_done;
        sts.mv_ge_top  = (mv_reg >= CURVE_MV[0]);
        sts.mv_le_bot  = (mv_reg <= CURVE_MV[CURVE_POINTS-1]);
        sts.seg_hit    = (mv_reg >= vl);
        sts.seg_flat   = (vh <= vl);
        sts.seg_last   = (k_reg == SEG_W'(CURVE_POINTS - 2));
        sts.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign supply_mv   = out_mv_reg;
    assign battery_pct = out_pct_reg;

endmodule

/* rtl/core/bpct_ctrl.sv */
// Controller state machine: sequences scaling, range check, segment walk,
// interpolation and output load. Depends on bpct_pkg.
module bpct_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bpct_pkg::bpct_sts_t sts,
    output bpct_pkg::bpct_cmd_t cmd
);

    import bpct_pkg::*;

    bpct_state_t state_reg;
    bpct_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = sts.skip ? ST_DONE : ST_SCALE;
            end
            ST_SCALE:
            begin
                if (sts.scale_done)
                    state_next = ST_RANGE;
            end
            ST_RANGE:
            begin
                if (sts.mv_ge_top || sts.mv_le_bot)
                    state_next = ST_DONE;
                else
                    state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                priority if (sts.seg_hit)
                    state_next = sts.seg_flat ? ST_DONE : ST_INTERP;
                else if (sts.seg_last)
                    state_next = ST_DONE;
                else
                    state_next = ST_SEARCH;
            end
            ST_INTERP:
            begin
                if (sts.div_done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (sts.skip)
                        cmd.load_zero = 1'b1;
                    else
                        cmd.start_scale = 1'b1;
                end
            end
            ST_SCALE:
            begin
                cmd.cap_mv = sts.scale_done;
            end
            ST_RANGE:
            begin
                priority if (sts.mv_ge_top)
                    cmd.pct_full = 1'b1;
                else if (sts.mv_le_bot)
                    cmd.pct_zero = 1'b1;
                else
                    cmd.seg_init = 1'b1;
            end
            ST_SEARCH:
            begin
                priority if (sts.seg_hit)
                begin
                    if (sts.seg_flat)
                        cmd.pct_upper = 1'b1;
                    else
                        cmd.start_interp = 1'b1;
                end
                else if (sts.seg_last)
                    cmd.pct_zero = 1'b1;
                else
                    cmd.seg_step = 1'b1;
            end
            ST_INTERP:
            begin
                cmd.cap_pct = sts.div_done;
            end
            ST_DONE:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/core/bpct_checker.sv */
// Port-level checker for the battery ADC to percent block, with its bind.
// Depends on bpct_pkg and on the top level battery_adc_to_percent.
module bpct_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [bpct_pkg::MV_W-1:0]  supply_mv,
    input logic [bpct_pkg::PCT_W-1:0] battery_pct
);

    import bpct_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(supply_mv) && $stable(battery_pct))
        else $error("result changed while stalled");

    // Percentage never exceeds full charge
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> battery_pct <= PCT_FULL)
        else $error("percentage above full");

    // Zero volts always gives zero percent
    a_zero_mv: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && supply_mv == '0 |-> battery_pct == PCT_ZERO)
        else $error("non-zero percentage at zero volts");

    // At or above the top of the curve the cell is full
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && supply_mv >= CURVE_MV[0] |-> battery_pct == PCT_FULL)
        else $error("not full above top of curve");

    // At or below the bottom of the curve the cell is empty
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && supply_mv <= CURVE_MV[CURVE_POINTS-1] |-> battery_pct == PCT_ZERO)
        else $error("not empty below bottom of curve");

endmodule

bind battery_adc_to_percent bpct_checker u_bpct_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .supply_mv   (supply_mv),
    .battery_pct (battery_pct)
);
